// ----- rtl/core/tcpc_pkg.sv -----
// shared types, register codes and symbol codes for the pulse classifier
`timescale 1ns / 1ps

package tcpc_pkg;

  // defaults for the top level parameters
  localparam int LockoutMsDefault     = 800;
  localparam int StuckMarginMsDefault = 200;
  localparam int QueueDepthDefault    = 4;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SNR_ON         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SNR_OFF        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STATUS_PRESENT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STATUS_WEAK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_MIN      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MAX       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_MAX        = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_MAX      = 3'd7;

  // symbol codes
  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_ONE    = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // input beat
  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] snr_level;
    logic [2:0]         signal_status;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic        symbol_valid;
    logic [1:0]  symbol_kind;
    logic [31:0] event_time;
    logic [15:0] width_measured;
    logic        pulse_active;
    logic [31:0] symbols_total;
    logic [31:0] lockout_rejects;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic signed [15:0] snr_on_level;
    logic signed [15:0] snr_off_level;
    logic [2:0]         status_present_level;
    logic [2:0]         status_weak_level;
    logic [15:0]        width_min;
    logic [15:0]        zero_width_max;
    logic [15:0]        one_width_max;
    logic [15:0]        width_max;
  } cfg_t;

  // queue entry: timestamp plus the two hysteresis decisions
  typedef struct packed {
    logic [31:0] sample_time;
    logic        present;
    logic        gone;
  } sample_flags_t;

endpackage

// ----- rtl/core/tcpc_front.sv -----
// front stage: registers each input beat with its present and gone decisions
`timescale 1ns / 1ps

module tcpc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  tcpc_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tcpc_pkg::in_item_t     in_data,
  output logic                   flags_valid,
  input  logic                   flags_ready,
  output tcpc_pkg::sample_flags_t flags_data
);
  import tcpc_pkg::*;

  logic          stage_valid;
  sample_flags_t stage_data;
  sample_flags_t stage_next;

  // hysteresis decisions on status and snr
  always_comb begin
    stage_next.sample_time = in_data.sample_time;
    stage_next.present = (in_data.signal_status >= cfg.status_present_level) ||
                         (in_data.snr_level >= cfg.snr_on_level);
    stage_next.gone    = (in_data.signal_status <= cfg.status_weak_level) &&
                         (in_data.snr_level < cfg.snr_off_level);
  end

  assign in_ready = !stage_valid || flags_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_data <= stage_next;
    end
  end

  assign flags_valid = stage_valid;
  assign flags_data  = stage_data;

endmodule

// ----- rtl/core/tcpc_queue.sv -----
// short queue between the front stage and the state update stage
`timescale 1ns / 1ps

module tcpc_queue #(
  parameter int DEPTH = tcpc_pkg::QueueDepthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  tcpc_pkg::sample_flags_t push_data,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output tcpc_pkg::sample_flags_t pop_data
);
  import tcpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sample_flags_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tcpc_back.sv -----
// back stage: pulse and lockout state, width classification, counters, output register
`timescale 1ns / 1ps

module tcpc_back #(
  parameter int LOCKOUT_MS      = tcpc_pkg::LockoutMsDefault,
  parameter int STUCK_MARGIN_MS = tcpc_pkg::StuckMarginMsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tcpc_pkg::cfg_t          cfg,
  input  logic                    flags_valid,
  output logic                    flags_ready,
  input  tcpc_pkg::sample_flags_t flags_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tcpc_pkg::out_item_t     out_data
);
  import tcpc_pkg::*;

  localparam logic [31:0] LockoutLen = 32'(LOCKOUT_MS);
  localparam logic [31:0] StuckLen   = 32'(STUCK_MARGIN_MS);

  logic        pulse_on;
  logic [31:0] pulse_begin;
  logic        lockout_on;
  logic [31:0] last_symbol_at;
  logic [31:0] symbol_counter;
  logic [31:0] reject_counter;
  logic        result_valid;
  out_item_t   result;

  logic        pulse_on_next;
  logic [31:0] pulse_begin_next;
  logic        lockout_on_next;
  logic [31:0] last_symbol_at_next;
  logic [31:0] symbol_counter_next;
  logic [31:0] reject_counter_next;
  out_item_t   result_next;

  logic        take;
  logic [31:0] since_symbol;
  logic        lock_now;
  logic [31:0] width;
  logic [1:0]  kind;
  logic [31:0] stuck_limit;

  assign take        = flags_valid && (!result_valid || out_ready);
  assign flags_ready = !result_valid || out_ready;

  // elapsed times, modulo 2^32
  assign since_symbol = flags_data.sample_time - last_symbol_at;
  assign width        = flags_data.sample_time - pulse_begin;
  assign lock_now     = lockout_on && (since_symbol < LockoutLen);
  assign stuck_limit  = {16'b0, cfg.width_max} + StuckLen;

  // width classification, range first
  always_comb begin
    if ((width < {16'b0, cfg.width_min}) || (width > {16'b0, cfg.width_max})) begin
      kind = KIND_NONE;
    end else if (width < {16'b0, cfg.zero_width_max}) begin
      kind = KIND_ZERO;
    end else if (width < {16'b0, cfg.one_width_max}) begin
      kind = KIND_ONE;
    end else begin
      kind = KIND_MARKER;
    end
  end

  // state update for one sample
  always_comb begin
    pulse_on_next       = pulse_on;
    pulse_begin_next    = pulse_begin;
    lockout_on_next     = lock_now;
    last_symbol_at_next = last_symbol_at;
    symbol_counter_next = symbol_counter;
    reject_counter_next = reject_counter;
    result_next         = '0;

    if (!pulse_on && flags_data.present && !lock_now) begin
      // rising edge
      pulse_on_next    = 1'b1;
      pulse_begin_next = flags_data.sample_time;
    end else if (pulse_on && flags_data.gone) begin
      // falling edge
      pulse_on_next = 1'b0;
      if (kind != KIND_NONE) begin
        symbol_counter_next        = symbol_counter + 1'b1;
        last_symbol_at_next        = flags_data.sample_time;
        lockout_on_next            = 1'b1;
        result_next.symbol_valid   = 1'b1;
        result_next.symbol_kind    = kind;
        result_next.event_time     = flags_data.sample_time;
        result_next.width_measured = (width[31:16] != '0) ? 16'hFFFF : width[15:0];
      end
    end else if (pulse_on) begin
      // drop a pulse that never ends
      if (width > stuck_limit) begin
        pulse_on_next = 1'b0;
      end
    end else if (flags_data.present && lock_now) begin
      // start blocked by lockout
      reject_counter_next = reject_counter + 1'b1;
    end

    result_next.pulse_active    = pulse_on_next;
    result_next.symbols_total   = symbol_counter_next;
    result_next.lockout_rejects = reject_counter_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_on       <= 1'b0;
      pulse_begin    <= '0;
      lockout_on     <= 1'b0;
      last_symbol_at <= '0;
      symbol_counter <= '0;
      reject_counter <= '0;
    end else if (take) begin
      pulse_on       <= pulse_on_next;
      pulse_begin    <= pulse_begin_next;
      lockout_on     <= lockout_on_next;
      last_symbol_at <= last_symbol_at_next;
      symbol_counter <= symbol_counter_next;
      reject_counter <= reject_counter_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (out_ready) begin
      result_valid <= 1'b0;
    end
    if (take) begin
      result <= result_next;
    end
  end

  assign out_valid = result_valid;
  assign out_data  = result;

endmodule

// ----- rtl/core/time_code_pulse_classifier.sv -----
// top level of the time code pulse width classifier
//
//   channel  direction  handshake                 beat
//   in       input      in_valid / in_ready       tcpc_pkg::in_item_t
//   out      output     out_valid / out_ready     tcpc_pkg::out_item_t
//   cfg      input      cfg_we (no wait)          cfg_index, cfg_data
//
// one beat per cycle sustained in both directions while out_ready is high;
// with an empty queue a beat passes the front register, then a queue
// slot, then the output register before it shows on out_valid. the state
// update in the back stage sets the rate.
// reset is synchronous: it clears pulse and lockout state, counters and
// the queue, and restores the register defaults.
// a stalled output fills the queue, then the front register, before
// in_ready drops.
`timescale 1ns / 1ps

module time_code_pulse_classifier #(
  parameter int LOCKOUT_MS      = tcpc_pkg::LockoutMsDefault,
  parameter int STUCK_MARGIN_MS = tcpc_pkg::StuckMarginMsDefault,
  parameter int QUEUE_DEPTH     = tcpc_pkg::QueueDepthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tcpc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tcpc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [tcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tcpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcpc_pkg::*;

  cfg_t          cfg;
  logic          front_valid;
  logic          front_ready;
  sample_flags_t front_data;
  logic          queue_valid;
  logic          queue_ready;
  sample_flags_t queue_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.snr_on_level         <= 16'sd2560;
      cfg.snr_off_level        <= 16'sd1536;
      cfg.status_present_level <= 3'd2;
      cfg.status_weak_level    <= 3'd1;
      cfg.width_min            <= 16'd100;
      cfg.zero_width_max       <= 16'd350;
      cfg.one_width_max        <= 16'd650;
      cfg.width_max            <= 16'd950;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SNR_ON:         cfg.snr_on_level         <= cfg_data;
        REG_SNR_OFF:        cfg.snr_off_level        <= cfg_data;
        REG_STATUS_PRESENT: cfg.status_present_level <= cfg_data[2:0];
        REG_STATUS_WEAK:    cfg.status_weak_level    <= cfg_data[2:0];
        REG_WIDTH_MIN:      cfg.width_min            <= cfg_data;
        REG_ZERO_MAX:       cfg.zero_width_max       <= cfg_data;
        REG_ONE_MAX:        cfg.one_width_max        <= cfg_data;
        REG_WIDTH_MAX:      cfg.width_max            <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: decisions per sample
  tcpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .flags_valid (front_valid),
    .flags_ready (front_ready),
    .flags_data  (front_data)
  );

  // queue between the two halves
  tcpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_data),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_data)
  );

  // back: state update and result
  tcpc_back #(
    .LOCKOUT_MS      (LOCKOUT_MS),
    .STUCK_MARGIN_MS (STUCK_MARGIN_MS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .flags_valid (queue_valid),
    .flags_ready (queue_ready),
    .flags_data  (queue_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/core/tcpc_checker.sv -----
// port-level checks on the classifier output, bound to the top level
`timescale 1ns / 1ps

module tcpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input tcpc_pkg::out_item_t out_data
);
  import tcpc_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // no symbol means the event fields are clear
  a_no_symbol_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.symbol_valid |->
      out_data.symbol_kind == KIND_ZERO && out_data.event_time == '0 &&
      out_data.width_measured == '0)
    else $error("event fields set without a symbol");

  // a symbol carries a real kind and ends the pulse
  a_symbol_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.symbol_valid |->
      out_data.symbol_kind != KIND_NONE && !out_data.pulse_active)
    else $error("bad symbol beat");

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output beat right after reset");

endmodule

bind time_code_pulse_classifier tcpc_checker u_tcpc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
